// ----- hdl/hpmc_pkg.sv -----
`default_nettype none

package hpmc_pkg;

  localparam int PIXEL_W = 8;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_INDEX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_H = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_V = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AVG = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 5'd16;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t ref_pixel;
    pixel_t prior_pixel;
  } in_t;

  typedef struct packed {
    pixel_t pred_pixel;
    logic   last_in_block;
  } out_t;

  typedef struct packed {
    logic half_h;
    logic half_v;
    logic avg;
  } mode_t;

  typedef struct packed {
    pixel_t above_left;
    pixel_t above;
    pixel_t left;
    pixel_t cur;
  } nbr_t;

endpackage

`default_nettype wire

// ----- hdl/hpmc_pred.sv -----
`default_nettype none

module hpmc_pred (
  input  hpmc_pkg::mode_t  mode,
  input  hpmc_pkg::nbr_t   nbr,
  input  hpmc_pkg::pixel_t prior,
  output hpmc_pkg::pixel_t pred
);

  logic [9:0] sum4;
  logic [8:0] sum_h;
  logic [8:0] sum_v;
  logic [8:0] sum_avg;
  hpmc_pkg::pixel_t base;

  assign sum4 = 10'(nbr.above_left) + 10'(nbr.above) + 10'(nbr.left) + 10'(nbr.cur) + 10'd2;
  assign sum_h = 9'(nbr.left) + 9'(nbr.cur) + 9'd1;
  assign sum_v = 9'(nbr.above) + 9'(nbr.cur) + 9'd1;

  always_comb begin
    if (mode.half_h && mode.half_v) begin
      base = sum4[9:2];
    end else if (mode.half_h) begin
      base = sum_h[8:1];
    end else if (mode.half_v) begin
      base = sum_v[8:1];
    end else begin
      base = nbr.cur;
    end
  end

  // bidirectional: average with the earlier prediction
  assign sum_avg = 9'(prior) + 9'(base) + 9'd1;
  assign pred = mode.avg ? sum_avg[8:1] : base;

endmodule

`default_nettype wire

// ----- hdl/half_pel_motion_compensation.sv -----
`default_nettype none

// Half-pel motion compensation for one block. The reference window streams in
// raster order, one pixel per word, and one word is taken every cycle unless
// the output register is held by out_stall; a prediction leaves through the
// output register, loaded by the word that completes it. Words in the leading
// row or column of an interpolated window give no result. The previous window
// row sits in a line store whose read is registered from the next column
// count, so the store's single read port sets the one-pixel-per-cycle rate;
// per-entry valid bits make it read as zero after reset, with no clearing pass.
module half_pel_motion_compensation #(
  parameter int MAX_WIDTH = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  hpmc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output hpmc_pkg::out_t                      out_data,
  input  wire                                 cfg_write,
  input  wire  [hpmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [hpmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int CWX = ((CW > hpmc_pkg::CFG_DATA_W) ? CW : hpmc_pkg::CFG_DATA_W) + 1;
  localparam int RWX = ((RW > hpmc_pkg::CFG_DATA_W) ? RW : hpmc_pkg::CFG_DATA_W) + 1;
  localparam int DEPTH = MAX_WIDTH + 1;

  // configuration
  logic                              half_h;
  logic                              half_v;
  logic                              avg;
  logic [hpmc_pkg::CFG_DATA_W-1:0]   block_width;
  logic [hpmc_pkg::CFG_DATA_W-1:0]   block_height;

  // window position
  logic [CW-1:0] column_count;
  logic [CW-1:0] column_count_next;
  logic [RW-1:0] row_count;
  logic [RW-1:0] row_count_next;

  // line store
  hpmc_pkg::pixel_t line_store [DEPTH];
  logic [DEPTH-1:0] store_vld;
  hpmc_pkg::pixel_t rd_data;
  logic             rd_vld;
  logic             byp;
  hpmc_pkg::pixel_t byp_data;

  hpmc_pkg::pixel_t left_pixel;
  hpmc_pkg::pixel_t above_left_pixel;
  hpmc_pkg::pixel_t above;

  logic [CWX-1:0] w_x;
  logic [CWX-1:0] last_col;
  logic [RWX-1:0] h_x;
  logic [RWX-1:0] last_row;
  logic           row_end;
  logic           win_end;
  logic           produce;
  logic           accept;

  hpmc_pkg::mode_t  mode;
  hpmc_pkg::nbr_t   nbr;
  hpmc_pkg::pixel_t pred;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_h <= 1'b0;
      half_v <= 1'b0;
      avg <= 1'b0;
      block_width <= hpmc_pkg::SIZE_RESET;
      block_height <= hpmc_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hpmc_pkg::REG_HALF_H: half_h <= cfg_data[0];
        hpmc_pkg::REG_HALF_V: half_v <= cfg_data[0];
        hpmc_pkg::REG_AVG:    avg <= cfg_data[0];
        hpmc_pkg::REG_WIDTH:  block_width <= cfg_data;
        hpmc_pkg::REG_HEIGHT: block_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp block size into 1..MAX
  always_comb begin
    if (block_width == '0) begin
      w_x = CWX'(1);
    end else if (CWX'(block_width) > CWX'(MAX_WIDTH)) begin
      w_x = CWX'(MAX_WIDTH);
    end else begin
      w_x = CWX'(block_width);
    end
    if (block_height == '0) begin
      h_x = RWX'(1);
    end else if (RWX'(block_height) > RWX'(MAX_HEIGHT)) begin
      h_x = RWX'(MAX_HEIGHT);
    end else begin
      h_x = RWX'(block_height);
    end
  end

  assign last_col = w_x + CWX'(half_h) - CWX'(1);
  assign last_row = h_x + RWX'(half_v) - RWX'(1);
  assign row_end = CWX'(column_count) >= last_col;
  assign win_end = row_end && (RWX'(row_count) >= last_row);
  assign produce = (!half_h || (column_count != '0)) && (!half_v || (row_count != '0));

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_comb begin
    column_count_next = column_count;
    row_count_next = row_count;
    if (accept) begin
      if (win_end) begin
        column_count_next = '0;
        row_count_next = '0;
      end else if (row_end) begin
        column_count_next = '0;
        row_count_next = row_count + RW'(1);
      end else begin
        column_count_next = column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
    end else begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

  // write the current pixel, prefetch the entry for the next word
  always_ff @(posedge clk) begin
    if (accept) begin
      line_store[column_count] <= in_data.ref_pixel;
    end
    rd_data <= line_store[column_count_next];
    byp_data <= in_data.ref_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
      rd_vld <= 1'b0;
      byp <= 1'b0;
    end else begin
      if (accept) begin
        store_vld[column_count] <= 1'b1;
      end
      rd_vld <= store_vld[column_count_next];
      byp <= accept && (column_count_next == column_count);
    end
  end

  assign above = byp ? byp_data : (rd_vld ? rd_data : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
      above_left_pixel <= '0;
    end else if (accept) begin
      left_pixel <= in_data.ref_pixel;
      above_left_pixel <= above;
    end
  end

  assign mode = '{half_h: half_h, half_v: half_v, avg: avg};
  assign nbr = '{above_left: above_left_pixel, above: above, left: left_pixel,
                 cur: in_data.ref_pixel};

  hpmc_pred u_pred (
    .mode  (mode),
    .nbr   (nbr),
    .prior (in_data.prior_pixel),
    .pred  (pred)
  );

  // output register: load on a producing word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      out_data.pred_pixel <= pred;
      out_data.last_in_block <= win_end;
    end
  end

endmodule

`default_nettype wire
